// ===== rtl/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned CNT_W = $clog2(BITS_PER_BYTE + 1);

   localparam logic [7:0] HOLD_TICKS_RESET = 8'd4;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

endpackage

// ===== rtl/i2c_master_byte_engine_core.sv =====
// I2C master byte engine. Each request is either a command (start or
// restart, stop, write byte, read byte), taken only while the engine is
// idle and ignored otherwise, or a tick that carries the sampled SDA level
// and advances the bus sequence by one step. Every request returns exactly
// one response with the SCL and SDA drive levels, busy, a done pulse, the
// last received byte and the last sampled acknowledge. Bus timing is
// counted in ticks: a hold lasts csr_wr_data ticks (0 counts as 1) and the
// low gap of a read bit half of that, rounded up. The engine takes one
// request per clock cycle: the whole step is one pass of logic into the
// state and response registers. The response is valid the cycle after its
// request is taken, and a new request can be taken in the same cycle as the
// previous response; only a response held back by rsp_ready low stalls
// req_ready.
module i2c_master_byte_engine_core
   import i2cmbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic [7:0] req_tx_byte,
   input  logic       req_send_nack,
   input  logic       req_sda_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_high,
   output logic       rsp_sda_low,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_data,
   output logic       rsp_ack_bit
);

   typedef enum logic [4:0] {
      PH_IDLE   = 5'd0,
      PH_ST1    = 5'd1,
      PH_ST2    = 5'd2,
      PH_SP1    = 5'd3,
      PH_SP2    = 5'd4,
      PH_WLOW   = 5'd5,
      PH_WHIGH  = 5'd6,
      PH_WACKLO = 5'd7,
      PH_WACKHI = 5'd8,
      PH_RHIGH  = 5'd9,
      PH_RLOW   = 5'd10,
      PH_RACK   = 5'd11
   } phase_type;

   localparam logic [CNT_W-1:0] BIT_COUNT_FULL = CNT_W'(BITS_PER_BYTE);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] bit_count_ff, bit_count_in, bit_count_dec;
   logic [7:0]       shift_ff, shift_in;
   logic [7:0]       wait_ff, wait_in;
   logic             scl_ff, scl_in;
   logic             sda_ff, sda_in;
   logic             ack_ff, ack_in;
   logic             nack_ff, nack_in;
   logic [7:0]       rx_ff, rx_in;
   logic [7:0]       hold_ticks_ff;
   logic             done_in;

   logic             rsp_valid_ff;
   logic             rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_ack_ff;
   logic [7:0]       rsp_rx_ff;

   logic [7:0]       hold_len;
   logic [8:0]       gap_sum;
   logic [7:0]       gap_len;
   logic             accept;
   logic             is_cmd;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign hold_len      = (hold_ticks_ff == 8'd0) ? 8'd1 : hold_ticks_ff;
   assign gap_sum       = {1'b0, hold_len} + 9'd1;
   assign gap_len       = gap_sum[8:1];
   assign bit_count_dec = bit_count_ff - CNT_W'(1);
   assign is_cmd        = (req_op == OP_START) || (req_op == OP_STOP) ||
                          (req_op == OP_WRITE) || (req_op == OP_READ);

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      ack_in       = ack_ff;
      nack_in      = nack_ff;
      rx_in        = rx_ff;
      done_in      = 1'b0;
      if (is_cmd) begin
         if (phase_ff == PH_IDLE) begin
            case (req_op)
               OP_START: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  phase_in = PH_ST1;
                  wait_in  = hold_len;
               end
               OP_STOP: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_SP1;
                  wait_in  = hold_len;
               end
               OP_WRITE: begin
                  bit_count_in = BIT_COUNT_FULL;
                  scl_in       = 1'b0;
                  sda_in       = ~req_tx_byte[7];
                  shift_in     = {req_tx_byte[6:0], 1'b0};
                  phase_in     = PH_WLOW;
                  wait_in      = 8'd0;
               end
               default: begin
                  shift_in     = 8'd0;
                  bit_count_in = BIT_COUNT_FULL;
                  nack_in      = req_send_nack;
                  sda_in       = 1'b0;
                  scl_in       = 1'b1;
                  phase_in     = PH_RHIGH;
                  wait_in      = hold_len;
               end
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         if (phase_ff != PH_WLOW && phase_ff != PH_WACKHI && wait_ff > 8'd1) begin
            wait_in = wait_ff - 8'd1;
         end else begin
            unique case (phase_ff)
               PH_ST1: begin
                  sda_in   = 1'b1;
                  phase_in = PH_ST2;
                  wait_in  = hold_len;
               end
               PH_ST2: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  phase_in = PH_IDLE;
                  wait_in  = 8'd0;
                  done_in  = 1'b1;
               end
               PH_SP1: begin
                  sda_in   = 1'b0;
                  phase_in = PH_SP2;
                  wait_in  = hold_len;
               end
               PH_SP2: begin
                  phase_in = PH_IDLE;
                  wait_in  = 8'd0;
                  done_in  = 1'b1;
               end
               PH_WLOW: begin
                  scl_in   = 1'b1;
                  phase_in = PH_WHIGH;
                  wait_in  = hold_len;
               end
               PH_WHIGH: begin
                  scl_in       = 1'b0;
                  bit_count_in = bit_count_dec;
                  if (bit_count_dec != '0) begin
                     sda_in   = ~shift_ff[7];
                     shift_in = {shift_ff[6:0], 1'b0};
                     phase_in = PH_WLOW;
                     wait_in  = 8'd0;
                  end else begin
                     sda_in   = 1'b0;
                     phase_in = PH_WACKLO;
                     wait_in  = hold_len;
                  end
               end
               PH_WACKLO: begin
                  scl_in   = 1'b1;
                  phase_in = PH_WACKHI;
                  wait_in  = 8'd0;
               end
               PH_WACKHI: begin
                  ack_in   = req_sda_level;
                  scl_in   = 1'b0;
                  phase_in = PH_IDLE;
                  wait_in  = 8'd0;
                  done_in  = 1'b1;
               end
               PH_RHIGH: begin
                  shift_in     = {shift_ff[6:0], req_sda_level};
                  scl_in       = 1'b0;
                  bit_count_in = bit_count_dec;
                  if (bit_count_dec == '0) begin
                     sda_in = nack_ff ? 1'b0 : 1'b1;
                  end
                  phase_in = PH_RLOW;
                  wait_in  = gap_len;
               end
               PH_RLOW: begin
                  scl_in   = 1'b1;
                  phase_in = (bit_count_ff != '0) ? PH_RHIGH : PH_RACK;
                  wait_in  = hold_len;
               end
               PH_RACK: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  rx_in    = shift_ff;
                  phase_in = PH_IDLE;
                  wait_in  = 8'd0;
                  done_in  = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
                  wait_in  = 8'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_TICKS_RESET;
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= 8'd0;
         wait_ff       <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b0;
         ack_ff        <= 1'b0;
         nack_ff       <= 1'b0;
         rx_ff         <= 8'd0;
         rsp_valid_ff  <= 1'b0;
         rsp_scl_ff    <= 1'b1;
         rsp_sda_ff    <= 1'b0;
         rsp_busy_ff   <= 1'b0;
         rsp_done_ff   <= 1'b0;
         rsp_rx_ff     <= 8'd0;
         rsp_ack_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            hold_ticks_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            wait_ff      <= wait_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            ack_ff       <= ack_in;
            nack_ff      <= nack_in;
            rx_ff        <= rx_in;
            rsp_valid_ff <= 1'b1;
            rsp_scl_ff   <= scl_in;
            rsp_sda_ff   <= sda_in;
            rsp_busy_ff  <= (phase_in != PH_IDLE);
            rsp_done_ff  <= done_in;
            rsp_rx_ff    <= rx_in;
            rsp_ack_ff   <= ack_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_scl_high = rsp_scl_ff;
   assign rsp_sda_low  = rsp_sda_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_rx_data  = rsp_rx_ff;
   assign rsp_ack_bit  = rsp_ack_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff)
      else $error("done reported while still busy");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_wlow_scl_low: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WLOW |-> !scl_ff)
      else $error("SCL released during write data setup");

   a_idle_wait_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> wait_ff == 8'd0)
      else $error("wait counter not cleared in idle");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BIT_COUNT_FULL)
      else $error("bit counter out of range");

endmodule
